>>> rtl/crc_pkg.sv
package crc_pkg;

	// Field widths fixed by the register map
	localparam int POLY_W    = 32;
	localparam int DEGREE_W  = 6;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY_LOW = 2'd0,
		REG_DEGREE   = 2'd1,
		REG_MODE     = 2'd2
	} reg_idx_t;

	// Operating modes
	typedef enum logic {
		MODE_GEN = 1'b0,
		MODE_CHK = 1'b1
	} mode_t;

	// Reset values of the registers
	localparam logic [POLY_W-1:0]   POLY_RESET   = 32'd4129;
	localparam logic [DEGREE_W-1:0] DEGREE_RESET = 6'd16;

	// One result item
	typedef struct packed {
		logic out_bit;
		logic is_check;
		logic error_found;
		logic last_out;
	} res_t;

endpackage

>>> rtl/crc_cell.sv
// One remainder bit of the division chain
module crc_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic clr,
	input  logic keep,
	input  logic nb,
	input  logic fb,
	input  logic pbit,
	output logic q,
	output logic nxt
);

	// shift in neighbor bit, subtract generator coefficient on feedback
	assign nxt = keep & (nb ^ (fb & pbit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= 1'b0;
		end else if (step) begin
			q <= clr ? 1'b0 : nxt;
		end
	end

endmodule

>>> rtl/crc_out_skid.sv
// Output register with one skid entry
module crc_out_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  crc_pkg::res_t push_res,
	input  logic          out_stall,
	output logic          full,
	output logic          out_valid,
	output crc_pkg::res_t out_res
);

	logic          main_v_q;
	logic          sk_v_q;
	crc_pkg::res_t main_q;
	crc_pkg::res_t sk_q;
	logic          take;

	assign take      = main_v_q & ~out_stall;
	assign full      = sk_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			sk_v_q   <= 1'b0;
		end else if (sk_v_q) begin
			if (take) begin
				sk_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_v_q || take) begin
				main_v_q <= 1'b1;
			end else begin
				sk_v_q <= 1'b1;
			end
		end else if (take) begin
			main_v_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (take) begin
				main_q <= sk_q;
			end
		end else if (push) begin
			if (!main_v_q || take) begin
				main_q <= push_res;
			end else begin
				sk_q <= push_res;
			end
		end
	end

endmodule

>>> rtl/crc_codeword_generate_check.sv
// Output: a result is registered in the output stage after its input transfer.
// Throughput: one bit per cycle while neither stall holds the input; in generate
// mode the last bit of a frame holds the input while degree check bits shift out
// of the cell chain, one per cycle unless the output stage is full.
// Reset: arst_n clears the remainder cells and all valid flags and loads the
// register reset values (poly_low 0x1021, degree 16, generate mode).
module crc_codeword_generate_check #(
	parameter int MAX_DEGREE = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [crc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [crc_pkg::POLY_W-1:0]      cfg_data,
	// input bits
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            data_bit,
	input  logic                            last_bit,
	// results
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            out_bit,
	output logic                            is_check,
	output logic                            error_found,
	output logic                            last_out
);

	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	logic [crc_pkg::POLY_W-1:0]   poly_q;
	logic [crc_pkg::DEGREE_W-1:0] degree_q;
	crc_pkg::mode_t               mode_q;

	logic [crc_pkg::DEGREE_W-1:0] deg_clamp;
	logic [DW-1:0]                deg;
	logic [DW-1:0]                deg_m1;
	logic [MAX_DEGREE-1:0]        rem;
	logic [MAX_DEGREE-1:0]        rem_nxt;
	logic [MAX_DEGREE-1:0]        keep;
	logic [MAX_DEGREE-1:0]        pbit;
	logic [MAX_DEGREE-1:0]        nb;
	logic                         top;
	logic                         fb;
	logic                         chk;

	logic                         emit_q;
	logic [DW-1:0]                cnt_q;
	logic                         emit_step;
	logic                         emit_end;
	logic                         in_xfer;
	logic                         step;
	logic                         clr;
	logic                         full;
	logic                         push;
	crc_pkg::res_t                push_res;
	crc_pkg::res_t                out_res;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q   <= crc_pkg::POLY_RESET;
			degree_q <= crc_pkg::DEGREE_RESET;
			mode_q   <= crc_pkg::MODE_GEN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				crc_pkg::REG_POLY_LOW: poly_q   <= cfg_data;
				crc_pkg::REG_DEGREE:   degree_q <= cfg_data[crc_pkg::DEGREE_W-1:0];
				crc_pkg::REG_MODE:     mode_q   <= crc_pkg::mode_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	// effective degree, clamped to 1..MAX_DEGREE
	always_comb begin
		if (degree_q == '0) begin
			deg_clamp = crc_pkg::DEGREE_W'(1);
		end else if (degree_q > crc_pkg::DEGREE_W'(MAX_DEGREE)) begin
			deg_clamp = crc_pkg::DEGREE_W'(MAX_DEGREE);
		end else begin
			deg_clamp = degree_q;
		end
	end

	assign deg    = deg_clamp[DW-1:0];
	assign deg_m1 = deg - DW'(1);
	assign top    = rem[deg_m1[IW-1:0]];
	assign chk    = (mode_q == crc_pkg::MODE_CHK);

	// handshake and sequencing
	assign in_stall  = full | emit_q;
	assign in_xfer   = in_valid & ~in_stall;
	assign emit_step = emit_q & ~full;
	assign emit_end  = (cnt_q == deg_m1);
	assign step      = in_xfer | emit_step;
	assign clr       = in_xfer & last_bit & chk;

	// feedback: check mode divides directly, generate mode is augmented,
	// check-bit shifting uses no feedback
	always_comb begin
		if (emit_q) begin
			fb = 1'b0;
		end else if (chk) begin
			fb = top;
		end else begin
			fb = top ^ data_bit;
		end
	end

	// cell chain
	assign nb[0] = ~emit_q & chk & data_bit;

	for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
		if (i > 0) begin : g_nb
			assign nb[i] = rem[i-1];
		end
		if (i < crc_pkg::POLY_W) begin : g_poly
			assign pbit[i] = poly_q[i];
		end else begin : g_nopoly
			assign pbit[i] = 1'b0;
		end
		assign keep[i] = (DW'(i) < deg);

		crc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.clr    (clr),
			.keep   (keep[i]),
			.nb     (nb[i]),
			.fb     (fb),
			.pbit   (pbit[i]),
			.q      (rem[i]),
			.nxt    (rem_nxt[i])
		);
	end

	// check-bit sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			cnt_q  <= '0;
		end else if (emit_step) begin
			if (emit_end) begin
				emit_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + DW'(1);
			end
		end else if (in_xfer && last_bit && !chk) begin
			emit_q <= 1'b1;
			cnt_q  <= '0;
		end
	end

	// result to output stage
	assign push = step;

	always_comb begin
		if (emit_q) begin
			push_res.out_bit     = top;
			push_res.is_check    = 1'b1;
			push_res.error_found = 1'b0;
			push_res.last_out    = emit_end;
		end else begin
			push_res.out_bit     = data_bit;
			push_res.is_check    = 1'b0;
			push_res.error_found = chk & last_bit & (|rem_nxt);
			push_res.last_out    = chk & last_bit;
		end
	end

	crc_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.out_stall (out_stall),
		.full      (full),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign out_bit     = out_res.out_bit;
	assign is_check    = out_res.is_check;
	assign error_found = out_res.error_found;
	assign last_out    = out_res.last_out;

endmodule

>>> rtl/crc_chk.sv
// Port-level checks for the CRC block
module crc_chk (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic out_bit,
	input logic is_check,
	input logic error_found,
	input logic last_out
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_bit) && $stable(is_check)
			&& $stable(error_found) && $stable(last_out))
		else $error("result changed while stalled");

	// an error flag only closes a frame
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_found |-> last_out)
		else $error("error flag on a result that is not last");

	// check bits never carry an error flag
	a_chk_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_check |-> !error_found)
		else $error("error flag on a check bit");

	// input is held off until the final check bit has left the chain
	a_emit_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_check && !last_out |-> in_stall)
		else $error("input taken while check bits pending");

endmodule

bind crc_codeword_generate_check crc_chk u_crc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_bit     (out_bit),
	.is_check    (is_check),
	.error_found (error_found),
	.last_out    (last_out)
);
